@@ hdl/dagt_pkg.sv @@
// dagt_pkg: shared constants, payload structs and state type
// for the dag table core; no dependencies
package dagt_pkg;

  localparam int unsigned MaxNodes = 16;
  localparam int unsigned NodeW    = $clog2(MaxNodes);
  localparam int unsigned CntW     = $clog2(MaxNodes + 1);
  localparam int unsigned AddrW    = 2 * NodeW;

  typedef enum logic [2:0] {
    KIND_ADD  = 3'd0,
    KIND_REM  = 3'd1,
    KIND_CON  = 3'd2,
    KIND_DIS  = 3'd3,
    KIND_SORT = 3'd4
  } kind_e;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] node_a;
    logic [3:0] node_b;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic       order_valid;
    logic [3:0] order_node;
    logic       last;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECODE,
    ST_REM_SCAN,    // walk own list of removed node, drop pred counts
    ST_REM_ROW,     // pick next row to purge
    ST_REM_RD,      // compact row: read entry
    ST_REM_WR,      // compact row: write back
    ST_REM_END,
    ST_CON_CHK,     // scan source list for duplicate
    ST_REACH_PICK,  // pick next frontier node
    ST_REACH_RD,    // walk its list
    ST_CON_END,
    ST_SORT_SEED,
    ST_SORT_POP,
    ST_SORT_RD,
    ST_SORT_END,
    ST_EMIT,
    ST_OUT
  } state_e;

endpackage

@@ hdl/dagt_datapath.sv @@
// dagt_datapath: graph state, successor memory and per-state step logic
// depends on dagt_pkg; driven by dagt_ctrl through state and command
module dagt_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dagt_pkg::state_e    state_i,
  input  dagt_pkg::in_item_t  item_i,
  input  logic                load_i,
  output dagt_pkg::out_item_t res_o,
  output logic [2:0]          kind_o,
  output logic                scan_done_o,
  output logic                list_end_o,
  output logic                rows_done_o,
  output logic                reach_done_o,
  output logic                node_ok_o,
  output logic                emit_last_o,
  output logic                sort_empty_o
);
  localparam int unsigned N  = dagt_pkg::MaxNodes;
  localparam int unsigned NW = dagt_pkg::NodeW;
  localparam int unsigned CW = dagt_pkg::CntW;

  logic [N-1:0]  present_q, visit_q, path_q;
  logic [CW-1:0] scnt_q [N];
  logic [CW-1:0] pcnt_q [N];
  logic [CW-1:0] wdeg_q [N];
  logic [NW-1:0] rq_q [N];
  logic [NW-1:0] succ_mem [N*N];

  logic [2:0]    kind_q;
  logic [NW-1:0] a_q, b_q, cur_q;
  logic [CW-1:0] k_q, w_q, head_q, tail_q;
  logic          hit_q, acc_q, any_q;
  logic [NW-1:0] rd_q;
  logic [NW:0]   row_q;
  logic          okab;
  logic [NW-1:0] drop_n;
  logic [N-1:0]  b_hot;

  assign okab   = present_q[a_q] && present_q[b_q];
  // node to strip from a list: the target for disconnect, else the removed node
  assign drop_n = (kind_q == dagt_pkg::KIND_DIS) ? b_q : a_q;
  assign b_hot  = {{(N-1){1'b0}}, 1'b1} << b_q;

  // memory read of entry (cur, k); writes for row compaction and connect append
  always_ff @(posedge clk_i) begin
    rd_q <= succ_mem[{cur_q, k_q[NW-1:0]}];
    if (state_i == dagt_pkg::ST_REM_WR && rd_q != drop_n)
      succ_mem[{cur_q, w_q[NW-1:0]}] <= rd_q;
    else if (state_i == dagt_pkg::ST_CON_END && acc_q && !visit_q[a_q])
      succ_mem[{a_q, scnt_q[a_q][NW-1:0]}] <= b_q;
  end

  // first set bit search
  function automatic logic [NW:0] first1(input logic [N-1:0] v);
    logic [NW:0] r;
    r = (NW+1)'(N);
    for (int i = N-1; i >= 0; i--) if (v[i]) r = (NW+1)'(i);
    return r;
  endfunction

  logic [NW:0] fp;
  assign fp = first1(path_q);

  // sequenced state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      for (int i = 0; i < N; i++) begin
        scnt_q[i] <= '0; pcnt_q[i] <= '0;
      end
      kind_q <= '0; a_q <= '0; b_q <= '0; cur_q <= '0;
      k_q <= '0; w_q <= '0; head_q <= '0; tail_q <= '0;
      hit_q <= 1'b0; acc_q <= 1'b0; any_q <= 1'b0;
      row_q <= '0; visit_q <= '0; path_q <= '0;
    end else if (load_i) begin
      kind_q <= item_i.kind; a_q <= item_i.node_a; b_q <= item_i.node_b;
      acc_q <= 1'b0; any_q <= 1'b0; k_q <= '0; hit_q <= 1'b0;
      cur_q <= item_i.node_a; row_q <= '0; head_q <= '0; tail_q <= '0;
    end else begin
      unique case (state_i)
        dagt_pkg::ST_DECODE: begin
          unique case (kind_q)
            dagt_pkg::KIND_ADD: if (!present_q[a_q]) begin
              present_q[a_q] <= 1'b1; scnt_q[a_q] <= '0; pcnt_q[a_q] <= '0;
              acc_q <= 1'b1;
            end
            dagt_pkg::KIND_DIS: begin
              acc_q <= okab; cur_q <= a_q; w_q <= '0;
            end
            dagt_pkg::KIND_CON: begin
              acc_q <= (a_q != b_q) && okab && (scnt_q[a_q] < CW'(N));
              visit_q <= b_hot; path_q <= b_hot;
            end
            default: ;
          endcase
        end
        // removal: own list drops pred counts (memory reads are registered)
        dagt_pkg::ST_REM_SCAN: begin
          if (hit_q) begin
            if (pcnt_q[rd_q] != '0) pcnt_q[rd_q] <= pcnt_q[rd_q] - CW'(1);
          end
          hit_q <= (k_q < scnt_q[a_q]);
          k_q <= k_q + CW'(1);
        end
        dagt_pkg::ST_REM_ROW: begin
          cur_q <= row_q[NW-1:0]; k_q <= '0; w_q <= '0;
          if (row_q[NW-1:0] == a_q) scnt_q[a_q] <= '0;
          row_q <= row_q + (NW+1)'(1);
        end
        dagt_pkg::ST_REM_RD: k_q <= k_q + CW'(1);
        dagt_pkg::ST_REM_WR: if (rd_q != drop_n) w_q <= w_q + CW'(1);
        dagt_pkg::ST_REM_END: begin
          scnt_q[cur_q] <= w_q;
          if (kind_q == dagt_pkg::KIND_DIS) begin
            if (w_q != scnt_q[cur_q] && pcnt_q[b_q] != '0)
              pcnt_q[b_q] <= pcnt_q[b_q] - CW'(1);
          end else if (rows_done_o) begin
            pcnt_q[a_q] <= '0; present_q[a_q] <= 1'b0; acc_q <= 1'b1;
          end
        end
        // connect: duplicate scan of a's list
        dagt_pkg::ST_CON_CHK: begin
          if (hit_q && rd_q == b_q) acc_q <= 1'b0;
          hit_q <= (k_q < scnt_q[a_q]);
          k_q <= k_q + CW'(1);
        end
        dagt_pkg::ST_REACH_PICK: begin
          if (fp != (NW+1)'(N)) begin
            cur_q <= fp[NW-1:0]; path_q[fp[NW-1:0]] <= 1'b0;
          end
          k_q <= '0; hit_q <= 1'b0;
        end
        dagt_pkg::ST_REACH_RD: begin
          if (hit_q && !visit_q[rd_q]) begin
            visit_q[rd_q] <= 1'b1; path_q[rd_q] <= 1'b1;
          end
          hit_q <= (k_q < scnt_q[cur_q]);
          k_q <= k_q + CW'(1);
        end
        dagt_pkg::ST_SORT_RD: begin
          if (hit_q && wdeg_q[rd_q] != '0) begin
            wdeg_q[rd_q] <= wdeg_q[rd_q] - CW'(1);
            if (wdeg_q[rd_q] == CW'(1) && tail_q < CW'(N)) begin
              rq_q[tail_q[NW-1:0]] <= rd_q; tail_q <= tail_q + CW'(1);
            end
          end
          hit_q <= (k_q < scnt_q[cur_q]);
          k_q <= k_q + CW'(1);
        end
        dagt_pkg::ST_CON_END: if (acc_q) begin
          if (visit_q[a_q]) acc_q <= 1'b0;
          else begin
            scnt_q[a_q] <= scnt_q[a_q] + CW'(1);
            pcnt_q[b_q] <= pcnt_q[b_q] + CW'(1);
          end
        end
        // sort seed, one slot per cycle
        dagt_pkg::ST_SORT_SEED: if (!row_q[NW]) begin
          wdeg_q[row_q[NW-1:0]] <= pcnt_q[row_q[NW-1:0]];
          if (present_q[row_q[NW-1:0]] && pcnt_q[row_q[NW-1:0]] == '0) begin
            rq_q[tail_q[NW-1:0]] <= row_q[NW-1:0]; tail_q <= tail_q + CW'(1);
          end
          row_q <= row_q + (NW+1)'(1);
        end
        dagt_pkg::ST_SORT_POP: begin
          cur_q <= rq_q[head_q[NW-1:0]]; head_q <= head_q + CW'(1);
          k_q <= '0; hit_q <= 1'b0; any_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // the popped node is emitted once its list is walked; last when queue dry; edits report accepted
  always_comb begin
    res_o = '0;
    res_o.last = 1'b1;
    if (kind_q == dagt_pkg::KIND_SORT) begin
      res_o.order_valid = any_q;
      res_o.order_node  = any_q ? cur_q : '0;
      res_o.last        = !(head_q < tail_q);
    end else if (kind_q <= dagt_pkg::KIND_DIS) begin
      res_o.accepted = acc_q;
    end
  end
  assign emit_last_o  = res_o.last;
  assign sort_empty_o = !(head_q < tail_q);

  // status: list walks, row search, frontier and node checks
  assign kind_o       = kind_q;
  assign scan_done_o  = !hit_q && (k_q != '0);
  assign list_end_o   = (k_q >= scnt_q[cur_q]);
  assign rows_done_o  = (row_q == (NW+1)'(N));
  assign reach_done_o = (path_q == '0);
  assign node_ok_o    = present_q[a_q];
endmodule

@@ hdl/dagt_ctrl.sv @@
// dagt_ctrl: sequencer for edits, cycle check and sort
// depends on dagt_pkg; steers dagt_datapath by its state code
module dagt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  input  logic [2:0]         kind_i,
  input  logic               scan_done_i,
  input  logic               list_end_i,
  input  logic               rows_done_i,
  input  logic               reach_done_i,
  input  logic               remove_ok_i,
  input  logic               sort_empty_i,
  input  logic               last_i,
  output dagt_pkg::state_e   state_o,
  output logic               load_o
);
  dagt_pkg::state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dagt_pkg::ST_IDLE: if (in_valid_i) state_d = dagt_pkg::ST_DECODE;
      dagt_pkg::ST_DECODE: begin
        unique case (kind_i)
          dagt_pkg::KIND_REM:
            state_d = remove_ok_i ? dagt_pkg::ST_REM_SCAN : dagt_pkg::ST_OUT;
          dagt_pkg::KIND_DIS:
            state_d = remove_ok_i ? dagt_pkg::ST_REM_RD : dagt_pkg::ST_OUT;
          dagt_pkg::KIND_CON:  state_d = dagt_pkg::ST_CON_CHK;
          dagt_pkg::KIND_SORT: state_d = dagt_pkg::ST_SORT_SEED;
          default:             state_d = dagt_pkg::ST_OUT;
        endcase
      end
      dagt_pkg::ST_REM_SCAN: if (scan_done_i) state_d = dagt_pkg::ST_REM_ROW;
      dagt_pkg::ST_REM_ROW:  state_d = dagt_pkg::ST_REM_RD;
      dagt_pkg::ST_REM_RD:   state_d = list_end_i ? dagt_pkg::ST_REM_END
                                                  : dagt_pkg::ST_REM_WR;
      dagt_pkg::ST_REM_WR:   state_d = dagt_pkg::ST_REM_RD;
      dagt_pkg::ST_REM_END: begin
        if (kind_i == dagt_pkg::KIND_DIS || rows_done_i) state_d = dagt_pkg::ST_OUT;
        else state_d = dagt_pkg::ST_REM_ROW;
      end
      dagt_pkg::ST_CON_CHK: if (scan_done_i) state_d = dagt_pkg::ST_REACH_PICK;
      dagt_pkg::ST_REACH_PICK:
        state_d = reach_done_i ? dagt_pkg::ST_CON_END : dagt_pkg::ST_REACH_RD;
      dagt_pkg::ST_REACH_RD: if (scan_done_i) state_d = dagt_pkg::ST_REACH_PICK;
      dagt_pkg::ST_CON_END:  state_d = dagt_pkg::ST_OUT;
      dagt_pkg::ST_SORT_SEED: if (rows_done_i) state_d = dagt_pkg::ST_SORT_END;
      dagt_pkg::ST_SORT_END:
        state_d = sort_empty_i ? dagt_pkg::ST_OUT : dagt_pkg::ST_SORT_POP;
      dagt_pkg::ST_SORT_POP: state_d = dagt_pkg::ST_SORT_RD;
      dagt_pkg::ST_SORT_RD:  if (scan_done_i) state_d = dagt_pkg::ST_EMIT;
      dagt_pkg::ST_EMIT: if (!out_stall_i)
        state_d = last_i ? dagt_pkg::ST_IDLE : dagt_pkg::ST_SORT_POP;
      dagt_pkg::ST_OUT: if (!out_stall_i) state_d = dagt_pkg::ST_IDLE;
      default: state_d = dagt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= dagt_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  // outputs
  always_comb begin
    state_o     = state_q;
    in_stall_o  = (state_q != dagt_pkg::ST_IDLE);
    load_o      = (state_q == dagt_pkg::ST_IDLE) && in_valid_i;
    out_valid_o = (state_q == dagt_pkg::ST_OUT) || (state_q == dagt_pkg::ST_EMIT);
  end
endmodule

@@ hdl/dag_table_with_topological_order_core.sv @@
// dag_table_with_topological_order_core: top level joining controller and datapath
// depends on dagt_pkg, dagt_ctrl, dagt_datapath
//
//  channel  | valid        | stall         | payload
//  ---------+--------------+---------------+----------------------
//  input    | in_valid_i   | in_stall_o    | in_data_i  (in_item_t)
//  output   | out_valid_o  | out_stall_i   | out_data_o (out_item_t)
//
// one item at a time; add and unknown kinds go from decode straight to the output state
// remove: own list walk, then each row is compacted by read and write-back steps (N = 16 rows)
// disconnect: one read and write-back pass over the source list
// connect: duplicate scan, then a walk of each reached node's list
// sort: seed pass over all N slots, then per sorted node a pop, a walk of its list and an emit
// reset clears node presence and counts at once; no clearing pass; stalls hold results
module dag_table_with_topological_order_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dagt_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dagt_pkg::out_item_t out_data_o
);
  dagt_pkg::state_e st;
  logic [2:0] kind;
  logic load, last, sempty, scan_done, list_end, rows_done, reach_done, node_ok;
  dagt_datapath u_dp (
    .clk_i, .rst_ni, .state_i(st), .item_i(in_data_i), .load_i(load),
    .res_o(out_data_o), .kind_o(kind), .scan_done_o(scan_done),
    .list_end_o(list_end), .rows_done_o(rows_done), .reach_done_o(reach_done),
    .node_ok_o(node_ok), .emit_last_o(last), .sort_empty_o(sempty)
  );
  dagt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_stall_i, .out_valid_o,
    .kind_i(kind), .scan_done_i(scan_done), .list_end_i(list_end),
    .rows_done_i(rows_done), .reach_done_i(reach_done),
    .remove_ok_i(node_ok), .sort_empty_i(sempty),
    .last_i(last), .state_o(st), .load_o(load)
  );
endmodule

@@ hdl/dagt_checker.sv @@
// dagt_props: port-level assertions for the dag table core
// depends on dagt_pkg; bound to the top level
module dagt_props (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input dagt_pkg::out_item_t out_data_o
);
  // a held result keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o)) else $error("hold");
  // no new item is taken while a result is pending
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("busy");
  // sort results never carry accepted
  a_sort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.order_valid |-> !out_data_o.accepted)
    else $error("sort acc");
endmodule

bind dag_table_with_topological_order_core dagt_props u_chk (.*);
